@@ sv/keyed_body_reassembly_slots_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keyed body reassembly block
// Same-cycle and next-cycle implication checks, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef KEYED_BODY_REASSEMBLY_SLOTS_TOP_MACROS_SVH
`define KEYED_BODY_REASSEMBLY_SLOTS_TOP_MACROS_SVH
`ifndef SYNTH
`define KBR_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KBR_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KBR_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define KBR_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

@@ sv/kbr_pkg.sv @@
// ----------------------------------------------------------------------------
// kbr_pkg
// Sizes, codes and control types shared by the reassembly modules.
// ----------------------------------------------------------------------------
package kbr_pkg;
  localparam int SLOT_COUNT    = 4;
  localparam int BODY_CAPACITY = 256;
  localparam int CLIENT_WIDTH  = 32;

  localparam int SLOT_W        = $clog2(SLOT_COUNT);
  localparam int LEN_W         = $clog2(BODY_CAPACITY + 1);
  localparam int ROWS_PER_SLOT = BODY_CAPACITY / 8;
  localparam int ROWS          = SLOT_COUNT * ROWS_PER_SLOT;
  localparam int ROW_W         = $clog2(ROWS);
  localparam int K_W           = $clog2(ROWS_PER_SLOT);

  localparam logic [2:0] OP_MORE     = 3'd0;
  localparam logic [2:0] OP_FINAL    = 3'd1;
  localparam logic [2:0] OP_ABORTED  = 3'd2;
  localparam logic [2:0] OP_COMPLETE = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  localparam logic [2:0] ST_WAITING   = 3'd0;
  localparam logic [2:0] ST_READY     = 3'd1;
  localparam logic [2:0] ST_CLEARED   = 3'd2;
  localparam logic [2:0] ST_BAD_ARG   = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;
  localparam logic [2:0] ST_MISMATCH  = 3'd5;

  typedef struct packed {
    logic load;
    logic commit;
    logic rd_step;
  } cmd_t;

  typedef struct packed {
    logic stream;
    logic rd_last;
  } sts_t;

  function automatic logic [SLOT_W-1:0] first_set(input logic [SLOT_COUNT-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (v[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction
endpackage

@@ sv/kbr_ram.sv @@
// ----------------------------------------------------------------------------
// kbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ sv/kbr_ctrl.sv @@
// ----------------------------------------------------------------------------
// kbr_ctrl
// Sequencer: capture a transaction, commit it, stream a ready body.
// ----------------------------------------------------------------------------
module kbr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  kbr_pkg::sts_t sts,
  output kbr_pkg::cmd_t cmd
);
  typedef enum logic [1:0] {IDLE, EVAL, STREAM} state_t;
  state_t state;

  assign busy = (state != IDLE);

  always_comb begin
    cmd = '0;
    cmd.load    = (state == IDLE) && start;
    cmd.commit  = (state == EVAL);
    cmd.rd_step = (state == STREAM);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE:    if (start) state <= EVAL;
        EVAL:    state <= sts.stream ? STREAM : IDLE;
        STREAM:  if (sts.rd_last) state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end
endmodule

@@ sv/kbr_datapath.sv @@
// ----------------------------------------------------------------------------
// kbr_datapath
// Slot table, byte-lane body store and result registers.
// ----------------------------------------------------------------------------
module kbr_datapath (
  input  logic          clk,
  input  logic          rst,
  input  kbr_pkg::cmd_t cmd,
  output kbr_pkg::sts_t sts,
  input  logic [2:0]    op,
  input  logic [31:0]   client_id,
  input  logic [15:0]   method_code,
  input  logic [15:0]   route_code,
  input  logic [63:0]   chunk_data,
  input  logic [3:0]    chunk_bytes,
  output logic          strobe,
  output logic [2:0]    status,
  output logic [8:0]    body_len,
  output logic [63:0]   body_word,
  output logic [3:0]    word_bytes,
  output logic          last
);
  localparam int SC = kbr_pkg::SLOT_COUNT;
  localparam int CW = kbr_pkg::CLIENT_WIDTH;
  localparam int SW = kbr_pkg::SLOT_W;
  localparam int LW = kbr_pkg::LEN_W;
  localparam int RW = kbr_pkg::ROW_W;
  localparam int KW = kbr_pkg::K_W;

  logic [2:0]    ip_op;
  logic [CW-1:0] ip_client;
  logic [15:0]   ip_method;
  logic [15:0]   ip_route;
  logic [63:0]   ip_data;
  logic [3:0]    ip_nbytes;

  logic          slot_active [SC];
  logic [CW-1:0] slot_client [SC];
  logic [15:0]   slot_method [SC];
  logic [15:0]   slot_route  [SC];
  logic [LW-1:0] slot_length [SC];

  logic [SC-1:0] hit_v, oth_v, free_v;
  logic [SW-1:0] hit_idx;
  logic [2:0]    dec_status;
  logic [SC-1:0] dec_free;
  logic          dec_alloc, dec_wr, dec_stream;
  logic [SW-1:0] dec_slot;
  logic [LW-1:0] cur_len, new_len;

  logic [SW-1:0] str_slot;
  logic [LW-1:0] str_len;
  logic [KW-1:0] rd_k, last_k;
  logic [LW-1:0] rem;
  logic [3:0]    wb;
  logic          mv, mlast;
  logic [3:0]    mwb;
  logic          sv;
  logic [2:0]    s_status;
  logic [63:0]   q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ip_op     <= op;
      ip_client <= client_id[CW-1:0];
      ip_method <= method_code;
      ip_route  <= route_code;
      ip_data   <= chunk_data;
      ip_nbytes <= chunk_bytes;
    end
  end

  always_comb begin
    for (int i = 0; i < SC; i++) begin
      hit_v[i]  = slot_active[i] && slot_client[i] == ip_client &&
                  slot_method[i] == ip_method && slot_route[i] == ip_route;
      oth_v[i]  = slot_active[i] && slot_client[i] == ip_client &&
                  (slot_method[i] != ip_method || slot_route[i] != ip_route);
      free_v[i] = !slot_active[i];
    end
  end

  assign hit_idx = kbr_pkg::first_set(hit_v);

  always_comb begin
    dec_status = kbr_pkg::ST_WAITING;
    dec_free   = '0;
    dec_alloc  = 1'b0;
    dec_wr     = 1'b0;
    dec_stream = 1'b0;
    dec_slot   = hit_idx;
    cur_len    = '0;
    new_len    = '0;
    if (ip_op == kbr_pkg::OP_CLEAR) begin
      dec_free   = hit_v;
      dec_status = kbr_pkg::ST_CLEARED;
    end else if (ip_client == '0) begin
      dec_status = kbr_pkg::ST_BAD_ARG;
    end else if (ip_op == kbr_pkg::OP_ABORTED || ip_op == kbr_pkg::OP_COMPLETE) begin
      dec_free   = hit_v;
      dec_status = kbr_pkg::ST_CLEARED;
    end else if (ip_op > kbr_pkg::OP_FINAL || ip_nbytes > 4'd8) begin
      dec_status = kbr_pkg::ST_BAD_ARG;
    end else if (hit_v == '0 && oth_v != '0) begin
      dec_free[kbr_pkg::first_set(oth_v)] = 1'b1;
      dec_status = kbr_pkg::ST_MISMATCH;
    end else if (hit_v == '0 && free_v == '0) begin
      dec_status = kbr_pkg::ST_MISMATCH;
    end else begin
      if (hit_v == '0) begin
        dec_slot  = kbr_pkg::first_set(free_v);
        dec_alloc = 1'b1;
      end else begin
        cur_len = slot_length[hit_idx];
      end
      new_len = cur_len + LW'(ip_nbytes);
      if (ip_nbytes != 4'd0 &&
          ({1'b0, cur_len} + (LW+1)'(ip_nbytes)) > (LW+1)'(kbr_pkg::BODY_CAPACITY)) begin
        dec_alloc  = 1'b0;
        dec_free   = hit_v;
        dec_status = kbr_pkg::ST_TOO_LARGE;
      end else begin
        dec_wr = (ip_nbytes != 4'd0);
        if (ip_op == kbr_pkg::OP_MORE) begin
          dec_status = kbr_pkg::ST_WAITING;
        end else begin
          dec_stream = 1'b1;
          dec_status = kbr_pkg::ST_READY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SC; i++) begin
        slot_active[i] <= 1'b0;
        slot_client[i] <= '0;
        slot_method[i] <= '0;
        slot_route[i]  <= '0;
        slot_length[i] <= '0;
      end
    end else if (cmd.commit) begin
      for (int i = 0; i < SC; i++) begin
        if (dec_free[i]) begin
          slot_active[i] <= 1'b0;
          slot_client[i] <= '0;
          slot_method[i] <= '0;
          slot_route[i]  <= '0;
          slot_length[i] <= '0;
        end else if (dec_slot == SW'(i) && (dec_alloc || dec_wr || dec_stream)) begin
          slot_active[i] <= 1'b1;
          slot_client[i] <= ip_client;
          slot_method[i] <= ip_method;
          slot_route[i]  <= ip_route;
          slot_length[i] <= new_len;
        end
      end
    end
  end

  assign last_k = (str_len == '0) ? '0 : KW'((str_len - LW'(1)) >> 3);
  assign rem    = str_len - LW'({rd_k, 3'b000});
  assign wb     = (rem > LW'(8)) ? 4'd8 : rem[3:0];

  genvar g;
  generate
    for (g = 0; g < 8; g++) begin : g_lane
      logic [2:0]    idx;
      logic          we;
      logic [RW-1:0] waddr;
      assign idx   = 3'(g) - cur_len[2:0];
      assign we    = cmd.commit && dec_wr && ({1'b0, idx} < ip_nbytes);
      assign waddr = RW'(dec_slot) * RW'(kbr_pkg::ROWS_PER_SLOT) + RW'(cur_len >> 3) +
                     RW'(3'(g) < cur_len[2:0]);
      kbr_ram #(.WIDTH(8), .DEPTH(kbr_pkg::ROWS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (ip_data[8*idx +: 8]),
        .raddr (RW'(str_slot) * RW'(kbr_pkg::ROWS_PER_SLOT) + RW'(rd_k)),
        .rdata (q[8*g +: 8])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
      sv <= 1'b0;
    end else begin
      mv <= cmd.rd_step;
      sv <= cmd.commit && !dec_stream;
    end
    if (cmd.commit) begin
      s_status <= dec_status;
      str_slot <= dec_slot;
      str_len  <= new_len;
      rd_k     <= '0;
    end else if (cmd.rd_step) begin
      rd_k <= rd_k + KW'(1);
    end
    mlast <= (rd_k == last_k);
    mwb   <= wb;
  end

  assign sts.stream  = dec_stream;
  assign sts.rd_last = (rd_k == last_k);

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      body_word[8*b +: 8] = (mv && 4'(b) < mwb) ? q[8*b +: 8] : 8'd0;
    end
  end

  assign strobe     = mv || sv;
  assign status     = mv ? kbr_pkg::ST_READY : s_status;
  assign body_len   = mv ? 9'(str_len) : 9'd0;
  assign word_bytes = mv ? mwb : 4'd0;
  assign last       = mv ? mlast : 1'b1;
endmodule

@@ sv/keyed_body_reassembly_slots_top.sv @@
// ----------------------------------------------------------------------------
// keyed_body_reassembly_slots_top
// Keyed request body reassembly in a small slot table.
// ----------------------------------------------------------------------------
// Usage:
//   Drive op, key fields and a chunk with start high; the transaction is
//   taken on an edge where start is high and busy is low.
//   Every transaction gives results on the result ports, each marked by
//   strobe for exactly one cycle; last marks the final one.
//   A non-final transaction gives a single result, which shows in the
//   first cycle with busy low, and the next transaction can be taken then.
//   A final chunk that is stored gives one ready result per 8-byte word,
//   one per cycle, max(1, ceil(len/8)) words; busy stays high while the
//   words are read from the single read port of the byte-lane body store.
//   A single result strobes from a result register written in EVAL; the
//   first ready word strobes from the registered RAM data read in STREAM.
//   The receiver cannot stall; results are never held.
//   Reset clears all slots at once; the body store needs no clearing pass.
// ----------------------------------------------------------------------------
`include "keyed_body_reassembly_slots_top_macros.svh"
module keyed_body_reassembly_slots_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [31:0] client_id,
  input  logic [15:0] method_code,
  input  logic [15:0] route_code,
  input  logic [63:0] chunk_data,
  input  logic [3:0]  chunk_bytes,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [8:0]  body_len,
  output logic [63:0] body_word,
  output logic [3:0]  word_bytes,
  output logic        last
);
  kbr_pkg::cmd_t cmd;
  kbr_pkg::sts_t sts;

  kbr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  kbr_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .op          (op),
    .client_id   (client_id),
    .method_code (method_code),
    .route_code  (route_code),
    .chunk_data  (chunk_data),
    .chunk_bytes (chunk_bytes),
    .strobe      (strobe),
    .status      (status),
    .body_len    (body_len),
    .body_word   (body_word),
    .word_bytes  (word_bytes),
    .last        (last)
  );

  `KBR_ASSERT_NXT(a_take_busy, clk, rst, start && !busy, busy)
  `KBR_ASSERT_IMP(a_simple_last, clk, rst, strobe && status != kbr_pkg::ST_READY, last)
  `KBR_ASSERT_NXT(a_stream_cont, clk, rst, strobe && status == kbr_pkg::ST_READY && !last,
                  strobe && status == kbr_pkg::ST_READY)
  `KBR_ASSERT_IMP(a_word_range, clk, rst, strobe, word_bytes <= 4'd8)
endmodule

@@ dv/keyed_body_reassembly_slots_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_body_reassembly_slots_top_tb
// Drives chunk, end and clear transactions into the slot table and checks
// every strobed result against a slot-table predictor kept in the bench.
// Directed corner cases come first, then random keyed sequences under
// several sender idling phases.
// ----------------------------------------------------------------------------
module keyed_body_reassembly_slots_top_tb;
  typedef struct {
    logic [2:0]  op;
    logic [31:0] client;
    logic [15:0] method;
    logic [15:0] route;
    logic [63:0] data;
    logic [3:0]  nbytes;
    int          idle_pct;
    bit          hold;
  } chunk_txn_t;

  typedef struct {
    logic [2:0]  status;
    logic [8:0]  len;
    logic [63:0] word;
    logic [3:0]  wbytes;
    logic        last;
  } body_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  op = '0;
  logic [31:0] client_id = '0;
  logic [15:0] method_code = '0;
  logic [15:0] route_code = '0;
  logic [63:0] chunk_data = '0;
  logic [3:0]  chunk_bytes = '0;
  logic        busy;
  logic        strobe;
  logic [2:0]  status;
  logic [8:0]  body_len;
  logic [63:0] body_word;
  logic [3:0]  word_bytes;
  logic        last;

  keyed_body_reassembly_slots_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .client_id(client_id), .method_code(method_code), .route_code(route_code),
    .chunk_data(chunk_data), .chunk_bytes(chunk_bytes), .strobe(strobe),
    .status(status), .body_len(body_len), .body_word(body_word),
    .word_bytes(word_bytes), .last(last)
  );

  always #5 clk = ~clk;

  chunk_txn_t pending_txns[$];
  chunk_txn_t cur_txn;
  body_res_t  expected_results[$];
  int         errors = 0;
  int         n_accepted = 0;
  int         n_total = 0;
  int         stall_cycles = 0;

  bit          slot_used[kbr_pkg::SLOT_COUNT];
  logic [31:0] slot_cl[kbr_pkg::SLOT_COUNT];
  logic [15:0] slot_me[kbr_pkg::SLOT_COUNT];
  logic [15:0] slot_ro[kbr_pkg::SLOT_COUNT];
  int unsigned slot_len[kbr_pkg::SLOT_COUNT];
  logic [7:0]  body_bytes[kbr_pkg::SLOT_COUNT * kbr_pkg::BODY_CAPACITY];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic drop_slot(input int s);
    slot_used[s] = 1'b0;
    slot_cl[s] = '0;
    slot_me[s] = '0;
    slot_ro[s] = '0;
    slot_len[s] = 0;
  endtask

  function automatic int find_key(input logic [31:0] c, input logic [15:0] m,
                                  input logic [15:0] r);
    for (int i = 0; i < kbr_pkg::SLOT_COUNT; i++)
      if (slot_used[i] && slot_cl[i] == c && slot_me[i] == m && slot_ro[i] == r)
        return i;
    return -1;
  endfunction

  task automatic push_single(input logic [2:0] st);
    body_res_t r;
    r = '{st, 9'd0, 64'd0, 4'd0, 1'b1};
    expected_results.push_back(r);
  endtask

  task automatic predict_body(input chunk_txn_t t);
    int s;
    int cnt;
    int unsigned len;
    int unsigned off;
    int unsigned wb;
    int unsigned base;
    body_res_t r;
    s = find_key(t.client, t.method, t.route);
    if (t.op == kbr_pkg::OP_CLEAR) begin
      if (s >= 0) drop_slot(s);
      push_single(kbr_pkg::ST_CLEARED);
      return;
    end
    if (t.client == 0) begin
      push_single(kbr_pkg::ST_BAD_ARG);
      return;
    end
    if (t.op == kbr_pkg::OP_ABORTED || t.op == kbr_pkg::OP_COMPLETE) begin
      if (s >= 0) drop_slot(s);
      push_single(kbr_pkg::ST_CLEARED);
      return;
    end
    if (t.op > kbr_pkg::OP_FINAL || t.nbytes > 8) begin
      push_single(kbr_pkg::ST_BAD_ARG);
      return;
    end
    if (s < 0) begin
      for (int i = 0; i < kbr_pkg::SLOT_COUNT; i++) begin
        if (slot_used[i] && slot_cl[i] == t.client &&
            (slot_me[i] != t.method || slot_ro[i] != t.route)) begin
          drop_slot(i);
          push_single(kbr_pkg::ST_MISMATCH);
          return;
        end
      end
      for (int i = 0; i < kbr_pkg::SLOT_COUNT; i++) begin
        if (!slot_used[i]) begin
          s = i;
          break;
        end
      end
      if (s < 0) begin
        push_single(kbr_pkg::ST_MISMATCH);
        return;
      end
      slot_used[s] = 1'b1;
      slot_cl[s] = t.client;
      slot_me[s] = t.method;
      slot_ro[s] = t.route;
      slot_len[s] = 0;
    end
    if (t.nbytes != 0) begin
      if (slot_len[s] > kbr_pkg::BODY_CAPACITY - t.nbytes) begin
        drop_slot(s);
        push_single(kbr_pkg::ST_TOO_LARGE);
        return;
      end
      base = s * kbr_pkg::BODY_CAPACITY + slot_len[s];
      for (int i = 0; i < t.nbytes; i++) body_bytes[base + i] = t.data[8*i +: 8];
      slot_len[s] += t.nbytes;
    end
    if (t.op == kbr_pkg::OP_MORE) begin
      push_single(kbr_pkg::ST_WAITING);
      return;
    end
    len = slot_len[s];
    cnt = (len + 7) / 8;
    if (cnt == 0) cnt = 1;
    base = s * kbr_pkg::BODY_CAPACITY;
    for (int k = 0; k < cnt; k++) begin
      off = k * 8;
      wb = (len > off) ? len - off : 0;
      if (wb > 8) wb = 8;
      r.word = '0;
      for (int i = 0; i < wb; i++) r.word[8*i +: 8] = body_bytes[base + off + i];
      r.status = kbr_pkg::ST_READY;
      r.len = len[8:0];
      r.wbytes = wb[3:0];
      r.last = (k == cnt - 1);
      expected_results.push_back(r);
    end
  endtask

  // driver
  always @(posedge clk) begin
    automatic bit took = 1'b0;
    automatic bit offer = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        predict_body(cur_txn);
        n_accepted++;
        took = 1'b1;
      end
      if (!start || took) begin
        if (pending_txns.size() != 0 &&
            !(pending_txns[0].hold && (took || expected_results.size() != 0)) &&
            $urandom_range(99) >= pending_txns[0].idle_pct)
          offer = 1'b1;
        if (offer) begin
          cur_txn = pending_txns.pop_front();
          op <= cur_txn.op;
          client_id <= cur_txn.client;
          method_code <= cur_txn.method;
          route_code <= cur_txn.route;
          chunk_data <= cur_txn.data;
          chunk_bytes <= cur_txn.nbytes;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    body_res_t e;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", {61'd0, status}, 64'd0);
      end else begin
        e = expected_results.pop_front();
        if (status !== e.status) report("status", status, e.status);
        if (body_len !== e.len) report("body_len", body_len, e.len);
        if (body_word !== e.word) report("body_word", body_word, e.word);
        if (word_bytes !== e.wbytes) report("word_bytes", word_bytes, e.wbytes);
        if (last !== e.last) report("last", last, e.last);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_txn(input logic [2:0] o, input logic [31:0] c, input logic [15:0] m,
                         input logic [15:0] r, input logic [63:0] d, input logic [3:0] n,
                         input int idle, input bit hold);
    chunk_txn_t t;
    t = '{o, c, m, r, d, n, idle, hold};
    pending_txns.push_back(t);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int idle;
    int pick;
    int nmore;
    int overflows;
    logic [31:0] c;
    logic [15:0] m;
    logic [15:0] r;
    logic [2:0] o;

    for (int i = 0; i < kbr_pkg::SLOT_COUNT; i++) drop_slot(i);

    add_txn(kbr_pkg::OP_CLEAR, 32'd0, 16'd0, 16'd0, 64'd0, 4'd0, 0, 0);
    add_txn(kbr_pkg::OP_MORE, 32'd0, 16'd1, 16'd1, rand64(), 4'd8, 0, 0);
    add_txn(kbr_pkg::OP_COMPLETE, 32'd0, 16'd1, 16'd1, 64'd0, 4'd0, 0, 0);
    add_txn(3'd5, 32'd7, 16'd1, 16'd1, 64'd0, 4'd0, 0, 0);
    add_txn(3'd7, 32'd7, 16'd1, 16'd1, 64'd0, 4'd0, 0, 0);
    add_txn(kbr_pkg::OP_MORE, 32'd7, 16'd1, 16'd1, rand64(), 4'd9, 0, 0);
    add_txn(kbr_pkg::OP_FINAL, 32'd7, 16'd1, 16'd1, rand64(), 4'd15, 0, 0);
    add_txn(kbr_pkg::OP_FINAL, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 64'd0, 4'd0, 0, 0);
    add_txn(kbr_pkg::OP_MORE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
            64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 0, 0);
    add_txn(kbr_pkg::OP_FINAL, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, rand64(), 4'd3, 0, 0);
    add_txn(kbr_pkg::OP_MORE, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, rand64(), 4'd1, 0, 0);
    add_txn(kbr_pkg::OP_MORE, 32'd1, 16'd0, 16'd0, rand64(), 4'd0, 0, 0);
    add_txn(kbr_pkg::OP_MORE, 32'd2, 16'd0, 16'd0, rand64(), 4'd5, 0, 0);
    add_txn(kbr_pkg::OP_MORE, 32'd3, 16'd0, 16'd0, rand64(), 4'd8, 0, 0);
    add_txn(kbr_pkg::OP_MORE, 32'd4, 16'd0, 16'd0, rand64(), 4'd2, 0, 0);
    add_txn(kbr_pkg::OP_MORE, 32'd5, 16'd0, 16'd0, rand64(), 4'd2, 0, 1);
    add_txn(kbr_pkg::OP_ABORTED, 32'd1, 16'd0, 16'd0, 64'd0, 4'd0, 0, 0);
    add_txn(kbr_pkg::OP_COMPLETE, 32'd2, 16'd0, 16'd0, 64'd0, 4'd0, 0, 0);
    add_txn(kbr_pkg::OP_CLEAR, 32'd3, 16'd0, 16'd0, 64'd0, 4'd0, 0, 0);
    add_txn(kbr_pkg::OP_FINAL, 32'd4, 16'd0, 16'd0, rand64(), 4'd6, 0, 0);
    add_txn(kbr_pkg::OP_CLEAR, 32'd4, 16'd0, 16'd0, 64'd0, 4'd0, 0, 1);

    overflows = 0;
    while (pending_txns.size() < 220) begin
      case ((pending_txns.size() / 50) % 4)
        0: idle = 0;
        1: idle = 78;
        2: idle = 19;
        default: idle = 0;
      endcase
      pick = $urandom_range(99);
      c = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 3);
      m = 16'(($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 1));
      r = 16'(($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 1));
      if (pick < 75) begin
        nmore = $urandom_range(0, 5);
        for (int i = 0; i < nmore; i++)
          add_txn(kbr_pkg::OP_MORE, c, m, r, rand64(), 4'($urandom_range(0, 8)), idle, 0);
        o = ($urandom_range(9) == 0) ?
            (($urandom_range(1)) ? kbr_pkg::OP_ABORTED : kbr_pkg::OP_COMPLETE) :
            kbr_pkg::OP_FINAL;
        add_txn(o, c, m, r, rand64(), 4'($urandom_range(0, 8)), idle,
                $urandom_range(19) == 0);
      end else if (pick < 80 && overflows < 3) begin
        overflows++;
        add_txn(kbr_pkg::OP_CLEAR, c, m, r, 64'd0, 4'd0, idle, 0);
        for (int i = 0; i < 32; i++)
          add_txn(kbr_pkg::OP_MORE, c, m, r, rand64(), 4'd8, idle, 0);
        add_txn((overflows == 1) ? kbr_pkg::OP_FINAL : kbr_pkg::OP_MORE, c, m, r, rand64(),
                (overflows == 1) ? 4'd0 : 4'd1, idle, 0);
      end else begin
        if ($urandom_range(9) == 0) c = 0;
        add_txn(3'($urandom_range(0, 7)), c, m, r, rand64(), 4'($urandom_range(0, 15)),
                idle, 0);
      end
    end
    n_total = pending_txns.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_total) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (expected_results.size() != 0)
      report("results never seen", expected_results.size(), 64'd0);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
